// ----- rtl/sce_pkg.sv -----
// Package for the smoothed softmax cross-entropy core: constants, types,
// exp ROM tables. No dependencies.
package sce_pkg;

    localparam int MAX_CLASSES_DEF = 1024;
    localparam int LOGIT_BITS_DEF  = 16;
    localparam int LABEL_BITS      = 10;
    localparam int EPS_BITS        = 16;
    localparam int LOSS_BITS       = 24;
    localparam int ACC_BITS        = 32;
    localparam int EXP_CUTOFF      = 16384;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [23:0] LOSS_MAX = 24'hFFFFFF;

    // queue entry between front and back
    typedef struct packed {
        logic        last;
        logic [LABEL_BITS-1:0] label;
    } sce_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EXP,
        ST_ACC,
        ST_LN_INIT,
        ST_LN_SQ,
        ST_LN_MUL,
        ST_DIV,
        ST_COMB,
        ST_OUT
    } back_state_t;

    // exp(-i) table, Q.31, i = 0..15
    typedef logic [31:0] int_rom_t [16];
    function automatic int_rom_t build_int();
        int_rom_t r;
        logic [63:0] a;
        a = 64'd2147483648;
        r[0] = a[31:0];
        for (int n = 1; n < 16; n++) begin
            a = (a * 64'd790015084 + 64'd1073741824) >> 31;
            r[n] = a[31:0];
        end
        return r;
    endfunction

    localparam int_rom_t INT_ROM = build_int();

    // exp(-f/1024) table, Q.31 (elaborated as constant array)
    typedef logic [31:0] frac_rom_t [1024];
    function automatic frac_rom_t build_frac();
        frac_rom_t r;
        logic [63:0] b;
        b = 64'd2147483648;
        r[0] = b[31:0];
        for (int n = 1; n < 1024; n++) begin
            b = (b * 64'd2145387520 + 64'd1073741824) >> 31;
            r[n] = b[31:0];
        end
        return r;
    endfunction

    localparam frac_rom_t FRAC_ROM = build_frac();

endpackage

// ----- rtl/sce_front.sv -----
// Front end: accepts logit requests, stores logits, tracks max/sum/count,
// pushes a command into the queue. Depends on sce_pkg.
module sce_front #(
    parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF,
    parameter int LOGIT_BITS  = sce_pkg::LOGIT_BITS_DEF,
    localparam int AW = $clog2(MAX_CLASSES),
    localparam int CW = $clog2(MAX_CLASSES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [LOGIT_BITS-1:0]  logit,
    input  logic [sce_pkg::LABEL_BITS-1:0] label,
    input  logic                          last,
    // store write port
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic signed [LOGIT_BITS-1:0]  wr_data,
    // sample statistics, valid while back end holds the sample
    output logic signed [LOGIT_BITS-1:0]  max_out,
    output logic signed [LOGIT_BITS+AW:0] sum_out,
    output logic [CW-1:0]                 count_out,
    // queue to back end
    output logic                          q_valid,
    output sce_pkg::sce_cmd_t             q_cmd,
    input  logic                          q_ready,
    input  logic                          back_done
);
    logic signed [LOGIT_BITS-1:0]  max_reg, max_next;
    logic signed [LOGIT_BITS+AW:0] sum_reg, sum_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;   // sample closed, back end owns it
    logic                          acc;
    logic                          room;

    assign in_ready = !busy_reg && q_ready;
    assign acc      = in_valid && in_ready;
    assign room     = (cnt_reg < CW'(MAX_CLASSES));

    assign wr_en   = acc && room;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = logit;

    assign q_valid     = acc && last;
    assign q_cmd.last  = last;
    assign q_cmd.label = label;

    assign max_out   = max_reg;
    assign sum_out   = sum_reg;
    assign count_out = cnt_reg;

    always_comb
    begin
        max_next  = max_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (wr_en)
        begin
            if (cnt_reg == '0 || logit > max_reg)
                max_next = logit;
            sum_next = sum_reg + (LOGIT_BITS+AW+1)'(logit);
            cnt_next = cnt_reg + 1'b1;
        end
        if (acc && last)
            busy_next = 1'b1;
        if (back_done)
        begin
            busy_next = 1'b0;
            max_next  = '0;
            sum_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            max_reg  <= max_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

// ----- rtl/sce_queue.sv -----
// Two-entry command queue between front and back end. Depends on sce_pkg.
module sce_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sce_pkg::sce_cmd_t push_cmd,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output sce_pkg::sce_cmd_t head
);
    sce_pkg::sce_cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign not_full  = (cnt_reg != 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && not_full)
            mem_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && not_full)
                wp_reg <= ~wp_reg;
            if (pop && not_empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((push && not_full) ? 1 : 0)
                               - 2'((pop && not_empty) ? 1 : 0);
        end
    end
endmodule

// ----- rtl/sce_back.sv -----
// Back end: exp-sum pass over the logit store, iterative log, divide and
// final combination; drives the result register. Depends on sce_pkg.
module sce_back #(
    parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF,
    parameter int LOGIT_BITS  = sce_pkg::LOGIT_BITS_DEF,
    localparam int AW = $clog2(MAX_CLASSES),
    localparam int CW = $clog2(MAX_CLASSES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  sce_pkg::sce_cmd_t             cmd,
    output logic                          cmd_pop,
    input  logic signed [LOGIT_BITS-1:0]  max_in,
    input  logic signed [LOGIT_BITS+AW:0] sum_in,
    input  logic [CW-1:0]                 count_in,
    input  logic [sce_pkg::EPS_BITS-1:0]  smoothing,
    output logic [AW-1:0]                 rd_addr,
    input  logic signed [LOGIT_BITS-1:0]  rd_data,
    output logic                          done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sce_pkg::LOSS_BITS-1:0] loss,
    output logic                          label_error
);
    localparam int SW  = LOGIT_BITS + AW + 1;   // logit sum width
    localparam int PW  = SW + 17;               // eps * sum width
    localparam int LW  = LOGIT_BITS + 40;       // Q.26 combination width
    localparam int PBW = 6;
    localparam int TW  = LOGIT_BITS + 16;       // exp argument, room for the cutoff
    localparam int LCW = (CW > sce_pkg::LABEL_BITS) ? CW : sce_pkg::LABEL_BITS;

    sce_pkg::back_state_t st_reg, st_next;
    logic [CW-1:0]   idx_reg, idx_next;        // read address counter
    logic [CW-1:0]   nrd_reg, nrd_next;        // terms accumulated
    logic            zy_pend_reg, zy_pend_next;
    logic            fdone_reg, fdone_next;    // all terms issued
    logic signed [LOGIT_BITS-1:0] zy_reg, zy_next;
    logic [LOGIT_BITS:0] t_reg, t_next;        // m - z, registered
    logic [31:0]     pa_reg, pa_next, pb_reg, pb_next;
    logic            tv_reg, tv_next;          // term in flight
    logic            rv_reg, rv_next;          // ROM words valid
    logic            pv_reg, pv_next;
    logic [63:0]     prod_reg, prod_next;
    logic [31:0]     sacc_reg, sacc_next;
    logic [PBW-1:0]  p_reg, p_next;
    logic [31:0]     x_reg, x_next;
    logic [15:0]     bits_reg, bits_next;
    logic [4:0]      k_reg, k_next;
    logic [19:0]     ln_reg, ln_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   rem_reg, rem_next, quo_reg, quo_next;
    logic [7:0]      dk_reg, dk_next;
    logic [sce_pkg::LOSS_BITS-1:0] loss_reg, loss_next;
    logic            err_reg, err_next;
    logic            ov_reg, ov_next;

    logic [63:0] sq;
    logic [32:0] sum_sat;
    logic [31:0] mag;
    logic [PW-1:0] eps_prod_abs;
    logic signed [PW:0] eps_prod;
    logic [PW:0] rem_sh;
    logic signed [LW-1:0] lq, lterm;
    logic signed [LOGIT_BITS+17:0] zprod;
    logic [LW-1:0] lround;
    logic [31:0] lg;
    logic [47:0] lnm;
    logic [31:0] xn;
    logic [TW-1:0] t_wide;

    assign rd_addr  = idx_reg[AW-1:0];
    assign out_valid = ov_reg;
    assign loss      = loss_reg;
    assign label_error = err_reg;

    always_comb
    begin
        st_next = st_reg;
        idx_next = idx_reg;
        nrd_next = nrd_reg;
        zy_pend_next = zy_pend_reg;
        fdone_next = fdone_reg;
        zy_next = zy_reg;
        t_next = t_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        tv_next = 1'b0;
        rv_next = 1'b0;
        pv_next = 1'b0;
        prod_next = prod_reg;
        sacc_next = sacc_reg;
        p_next = p_reg;
        x_next = x_reg;
        bits_next = bits_reg;
        k_next = k_reg;
        ln_next = ln_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dk_next = dk_reg;
        loss_next = loss_reg;
        err_next = err_reg;
        ov_next = ov_reg && !out_ready;
        cmd_pop = 1'b0;
        done = 1'b0;
        sq = 64'(x_reg) * 64'(x_reg);
        xn = sq[61:30];
        sum_sat = 33'(sacc_reg) + 33'(prod_reg[63:46]) + 33'(prod_reg[45]);
        mag = '0;
        eps_prod = $signed({1'b0, smoothing}) * sum_in;
        eps_prod_abs = eps_prod[PW] ? PW'(-eps_prod) : PW'(eps_prod);
        rem_sh = {rem_reg, quo_reg[PW-1]};
        t_wide = TW'(t_reg);
        lg = '0;
        lnm = '0;
        lq = '0;
        lterm = '0;
        zprod = '0;
        lround = '0;
        unique case (st_reg)
            sce_pkg::ST_IDLE:
            begin
                if (cmd_valid && !ov_reg)
                begin
                    cmd_pop = 1'b1;
                    if (count_in == '0 || LCW'(cmd.label) >= LCW'(count_in))
                    begin
                        loss_next = '0;
                        err_next = 1'b1;
                        st_next = sce_pkg::ST_OUT;
                    end
                    else
                    begin
                        err_next = 1'b0;
                        idx_next = '0;
                        nrd_next = '0;
                        sacc_next = '0;
                        zy_pend_next = 1'b1;
                        fdone_next = 1'b0;
                        st_next = sce_pkg::ST_RD;
                        // first fetch the target logit
                        idx_next = CW'(cmd.label);
                    end
                end
            end
            sce_pkg::ST_RD:
            begin
                // store read at label is issued now; its data arrives in ST_EXP
                st_next = sce_pkg::ST_EXP;
                idx_next = '0;
            end
            sce_pkg::ST_EXP:
            begin
                // pipeline: read -> t -> ROM -> product -> accumulate
                if (zy_pend_reg)
                begin
                    zy_next = rd_data;
                    zy_pend_next = 1'b0;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!fdone_reg)
                begin
                    // rd_data holds the entry at idx_reg - 1
                    t_next = (LOGIT_BITS+1)'(max_in) - (LOGIT_BITS+1)'(rd_data);
                    tv_next = 1'b1;
                    if (idx_reg != count_in)
                        idx_next = idx_reg + 1'b1;
                    else
                        fdone_next = 1'b1;
                end
                if (tv_reg)
                begin
                    rv_next = 1'b1;
                    if (t_wide >= TW'(sce_pkg::EXP_CUTOFF))
                        pa_next = '0;
                    else
                        pa_next = sce_pkg::INT_ROM[t_wide[13:10]];
                    pb_next = sce_pkg::FRAC_ROM[t_wide[9:0]];
                end
                if (rv_reg)
                begin
                    pv_next = 1'b1;
                    prod_next = 64'(pa_reg) * 64'(pb_reg);
                end
                if (pv_reg)
                begin
                    sacc_next = sum_sat[32] ? 32'hFFFFFFFF : sum_sat[31:0];
                    nrd_next = nrd_reg + 1'b1;
                end
                if (pv_reg && nrd_reg + 1'b1 == count_in)
                    st_next = sce_pkg::ST_LN_INIT;
            end
            sce_pkg::ST_LN_INIT:
            begin
                mag = (sacc_reg < 32'd65536) ? 32'd65536 : sacc_reg;
                p_next = '0;
                for (int b = 0; b < 32; b++)
                    if (mag[b])
                        p_next = PBW'(b);
                x_next = mag << (5'd30 - 5'(p_next));
                if (p_next == PBW'(31))
                    x_next = mag >> 1;
                bits_next = '0;
                k_next = '0;
                st_next = sce_pkg::ST_LN_SQ;
            end
            sce_pkg::ST_LN_SQ:
            begin
                if (xn[31])
                begin
                    x_next = xn >> 1;
                    bits_next = {bits_reg[14:0], 1'b1};
                end
                else
                begin
                    x_next = xn;
                    bits_next = {bits_reg[14:0], 1'b0};
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 5'd15)
                    st_next = sce_pkg::ST_LN_MUL;
            end
            sce_pkg::ST_LN_MUL:
            begin
                lg = {11'd0, 5'(p_reg - PBW'(16)), bits_reg};
                lnm = 48'(lg) * 48'(sce_pkg::LN2_Q16) + 48'd32768;
                ln_next = lnm[35:16];
                // start restoring division of |eps*sum| by count
                neg_next = eps_prod[PW];
                quo_next = eps_prod_abs;
                rem_next = '0;
                dk_next = '0;
                st_next = sce_pkg::ST_DIV;
            end
            sce_pkg::ST_DIV:
            begin
                if (rem_sh >= (PW+1)'(count_in))
                begin
                    rem_next = PW'(rem_sh - (PW+1)'(count_in));
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = PW'(rem_sh);
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                dk_next = dk_reg + 1'b1;
                if (dk_reg == 8'(PW - 1))
                    st_next = sce_pkg::ST_COMB;
            end
            sce_pkg::ST_COMB:
            begin
                zprod = $signed({1'b0, 17'd65536 - 17'(smoothing)})
                        * (LOGIT_BITS+18)'(zy_reg);
                lq = (LW'(max_in) <<< 16) + LW'({1'b0, ln_reg, 10'd0}) - LW'(zprod);
                lterm = neg_reg ? LW'(quo_reg) : -LW'(quo_reg);
                lq = lq + lterm;
                if (lq <= 0)
                    loss_next = '0;
                else
                begin
                    lround = (LW'(lq) + LW'(512)) >> 10;
                    loss_next = (lround > LW'(sce_pkg::LOSS_MAX)) ? sce_pkg::LOSS_MAX
                                                                   : lround[23:0];
                end
                st_next = sce_pkg::ST_OUT;
            end
            sce_pkg::ST_OUT:
            begin
                ov_next = 1'b1;
                done = 1'b1;
                st_next = sce_pkg::ST_IDLE;
            end
            default: st_next = sce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        zy_reg   <= zy_next;
        t_reg    <= t_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        bits_reg <= bits_next;
        ln_reg   <= ln_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        loss_reg <= loss_next;
        err_reg  <= err_next;
        p_reg    <= p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= sce_pkg::ST_IDLE;
            idx_reg     <= '0;
            nrd_reg     <= '0;
            zy_pend_reg <= 1'b0;
            fdone_reg   <= 1'b0;
            tv_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            pv_reg      <= 1'b0;
            sacc_reg    <= '0;
            k_reg       <= '0;
            dk_reg      <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            idx_reg     <= idx_next;
            nrd_reg     <= nrd_next;
            zy_pend_reg <= zy_pend_next;
            fdone_reg   <= fdone_next;
            tv_reg      <= tv_next;
            rv_reg      <= rv_next;
            pv_reg      <= pv_next;
            sacc_reg    <= sacc_next;
            k_reg       <= k_next;
            dk_reg      <= dk_next;
            ov_reg      <= ov_next;
        end
    end
endmodule

// ----- rtl/softmax_cross_entropy_smoothed_core.sv -----
// Smoothed softmax cross-entropy core. After the last request of a sample the
// back end runs an exp pass over the logit store, a 16-step log and a
// bit-serial divide by the class count; a bad label skips these and goes
// straight to the result.
// Throughput: one logit request per cycle while a sample is loading; no new
// sample is taken until the back end has finished the current one.
// Reset (rst_n, async, low) clears control, statistics and smoothing = 0.
// Depends on sce_pkg, sce_front, sce_queue, sce_back.
module softmax_cross_entropy_smoothed_core #(
    parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF,
    parameter int LOGIT_BITS  = sce_pkg::LOGIT_BITS_DEF,
    localparam int AW = $clog2(MAX_CLASSES),
    localparam int CW = $clog2(MAX_CLASSES + 1),
    localparam int IW = ((LOGIT_BITS + sce_pkg::LABEL_BITS + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata,       // smoothing, Q0.16
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [IW-1:0]  s_axis_tdata,    // logit, label
    input  logic           s_axis_tlast,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [23:0]    m_axis_tdata,    // loss
    output logic           m_axis_tuser     // label_error
);
    logic [15:0] smooth_reg;
    logic signed [LOGIT_BITS-1:0] logit;
    logic [sce_pkg::LABEL_BITS-1:0] label;
    logic signed [LOGIT_BITS-1:0] mem [MAX_CLASSES];
    logic signed [LOGIT_BITS-1:0] rd_data_reg;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [LOGIT_BITS-1:0] wr_data, max_v;
    logic signed [LOGIT_BITS+AW:0] sum_v;
    logic [CW-1:0] cnt_v;
    logic q_push, q_nf, q_pop, q_ne, done;
    sce_pkg::sce_cmd_t q_in, q_head;

    assign logit = s_axis_tdata[LOGIT_BITS-1:0];
    assign label = s_axis_tdata[LOGIT_BITS +: sce_pkg::LABEL_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smooth_reg <= '0;
        else if (cfg_we)
            smooth_reg <= cfg_wdata;
    end

    // logit store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    sce_front #(.MAX_CLASSES(MAX_CLASSES), .LOGIT_BITS(LOGIT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .logit(logit), .label(label), .last(s_axis_tlast),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .max_out(max_v), .sum_out(sum_v), .count_out(cnt_v),
        .q_valid(q_push), .q_cmd(q_in), .q_ready(q_nf), .back_done(done)
    );

    sce_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_cmd(q_in), .not_full(q_nf),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    sce_back #(.MAX_CLASSES(MAX_CLASSES), .LOGIT_BITS(LOGIT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop),
        .max_in(max_v), .sum_in(sum_v), .count_in(cnt_v),
        .smoothing(smooth_reg),
        .rd_addr(rd_addr), .rd_data(rd_data_reg),
        .done(done),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .loss(m_axis_tdata), .label_error(m_axis_tuser)
    );
endmodule

// ----- bench/softmax_cross_entropy_smoothed_core_test.sv -----
// Testbench for softmax_cross_entropy_smoothed_core: streams logit samples,
// predicts each loss in fixed point and checks every result request.
// Depends on sce_pkg and the core RTL.
`timescale 1ns / 1ps

module softmax_cross_entropy_smoothed_core_test;

    localparam int NCLS = 1024;

    typedef struct {
        logic [23:0] loss;
        logic        lab_err;
    } loss_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // logit [15:0], label [25:16]
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;         // loss [23:0]
    wire         m_axis_tuser;         // label_error

    softmax_cross_entropy_smoothed_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Predictor state: exp tables, logits of the open sample, running stats.
    logic [63:0]   exp_int_tab [16];
    logic [63:0]   exp_frac_tab [1024];
    logic signed [15:0] held_logit [NCLS];
    int            held_count;
    longint        peak_logit;
    longint        logit_sum;
    logic [15:0]   eps_q16;
    loss_result_t  loss_q [$];

    int   err_count;
    int   burst_left;
    int   gap_max;      // 0 turns sender gaps off
    int   stall_mode;   // 0: receiver always ready

    // Receiver stall pattern: mode 1 is mostly ready with short stalls; mode 2 inverts it.
    int stall_run;
    always @(posedge clk)
    begin
        if (stall_mode == 0)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if (stall_run == 0)
                stall_run = $urandom_range(1, 12);
            stall_run--;
            m_axis_tready <= (stall_run % 3 != 0) ^ (stall_mode == 2);
        end
    end

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        loss_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (loss_q.size() == 0)
            begin
                report($sformatf("unexpected result loss=%h err=%b",
                                 m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want = loss_q.pop_front();
                if (m_axis_tdata !== want.loss)
                    report($sformatf("loss %h, expected %h", m_axis_tdata, want.loss));
                if (m_axis_tuser !== want.lab_err)
                    report($sformatf("label_error %b, expected %b",
                                     m_axis_tuser, want.lab_err));
            end
        end
    end

    function automatic void build_exp_tables();
        exp_int_tab[0] = 64'd1 << 31;
        for (int n = 1; n < 16; n++)
            exp_int_tab[n] = (exp_int_tab[n-1] * 64'd790015084 + (64'd1 << 30)) >> 31;
        exp_frac_tab[0] = 64'd1 << 31;
        for (int n = 1; n < 1024; n++)
            exp_frac_tab[n] = (exp_frac_tab[n-1] * 64'd2145387520 + (64'd1 << 30)) >> 31;
    endfunction

    // exp(-t) in Q.16 for t in Q.10, zero from 16.0 up
    function automatic logic [63:0] exp_term(input logic [63:0] t);
        if (t >= 64'd16384)
            return 64'd0;
        return (exp_int_tab[t[13:10]] * exp_frac_tab[t[9:0]] + (64'd1 << 45)) >> 46;
    endfunction

    // natural log in Q.16 via log2 by repeated squaring
    function automatic logic [63:0] ln_term(input logic [63:0] s);
        int          msb;
        logic [63:0] x;
        logic [63:0] frac_bits;
        logic [63:0] lg;
        if (s < 64'd65536)
            s = 64'd65536;
        msb = 0;
        for (int b = 0; b < 64; b++)
            if (s[b])
                msb = b;
        x = (msb >= 30) ? (s >> (msb - 30)) : (s << (30 - msb));
        frac_bits = 0;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 30;
            frac_bits = frac_bits << 1;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                frac_bits[0] = 1'b1;
            end
        end
        lg = (64'(msb - 16) << 16) | frac_bits;
        return (lg * 64'd45426 + 64'd32768) >> 16;
    endfunction

    // Called once per accepted request; closes the sample on last.
    function automatic void predict_loss(input logic signed [15:0] z,
                                         input logic [9:0] label, input logic last);
        loss_result_t r;
        logic [63:0]  exp_sum;
        longint       acc;
        longint       eps;
        if (held_count < NCLS)
        begin
            held_logit[held_count] = z;
            if (held_count == 0 || z > peak_logit)
                peak_logit = z;
            logit_sum += z;
            held_count++;
        end
        if (!last)
            return;
        if (held_count == 0 || label >= held_count)
        begin
            r.loss = '0;
            r.lab_err = 1'b1;
        end
        else
        begin
            exp_sum = 0;
            for (int j = 0; j < held_count; j++)
            begin
                exp_sum += exp_term(64'(peak_logit - held_logit[j]));
                if (exp_sum > 64'hFFFF_FFFF)
                    exp_sum = 64'hFFFF_FFFF;
            end
            eps = eps_q16;
            acc = peak_logit * 65536 + longint'(ln_term(exp_sum)) * 1024;
            acc -= (65536 - eps) * longint'(held_logit[label]);
            acc -= (eps * logit_sum) / longint'(held_count);
            if (acc <= 0)
                r.loss = '0;
            else if (((acc + 512) >>> 10) > 64'hFFFFFF)
                r.loss = 24'hFFFFFF;
            else
                r.loss = 24'((acc + 512) >>> 10);
            r.lab_err = 1'b0;
        end
        loss_q.push_back(r);
        held_count = 0;
        peak_logit = 0;
        logit_sum = 0;
    endfunction

    // One logit request, with bursty sender gaps.
    task automatic send_logit(input logic signed [15:0] z, input logic [9:0] label,
                              input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, label, z};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_loss(z, label, last);
    endtask

    // Whole sample; every request carries a label, random but for the last, and only the last counts.
    task automatic send_sample(input logic signed [15:0] vals [$], input logic [9:0] label);
        for (int j = 0; j < vals.size(); j++)
            send_logit(vals[j], (j == vals.size() - 1) ? label : 10'($urandom),
                       j == vals.size() - 1);
    endtask

    // Drop valid, wait for every loss, then let the back end settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (loss_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_smoothing(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        eps_q16 = v;
    endtask

    task automatic test_directed();
        logic signed [15:0] v [$];
        v = '{16'sd500};                         send_sample(v, 10'd0);
        v = '{16'sd5};                           send_sample(v, 10'd3);    // label error
        v = '{16'sh7FFF, -16'sh8000};            send_sample(v, 10'd1);    // full span
        v = '{-16'sh8000, 16'sh7FFF};            send_sample(v, 10'd1);
        v = '{16'sd1024, 16'sd1024, 16'sd1024};  send_sample(v, 10'd2);    // equal logits
        v = '{16'sd0, 16'sd16384, 16'sd16383};   send_sample(v, 10'd0);    // exp cutoff edge
        v = '{16'sd100, -16'sd100};              send_sample(v, 10'h3FF);  // label error
        v = '{16'sd2047, 16'sd1, -16'sd1, 16'sd0, 16'sh5555, -16'sh2AAB};
        send_sample(v, 10'd4);
    endtask

    task automatic test_random_samples(input int items);
        logic signed [15:0] v [$];
        int n, centre, spread, sent;
        logic [9:0] label;
        sent = 0;
        while (sent < items)
        begin
            v = {};
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 10);
            centre = $signed(16'($urandom));
            spread = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(1, 4096);
            for (int j = 0; j < n; j++)
            begin
                if (spread == 32768)
                    v.push_back(16'($urandom));
                else
                    v.push_back(16'(centre + $signed($urandom_range(0, 2 * spread)) - spread));
            end
            label = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(n, 1023))
                                                : 10'($urandom_range(0, n - 1));
            send_sample(v, label);
            sent += n;
            // sender waits for the back end now and then
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    // More than the store holds: extra logits, the last one too, are dropped.
    task automatic test_store_overflow();
        logic signed [15:0] v [$];
        for (int j = 0; j < NCLS + 6; j++)
            v.push_back(16'($urandom_range(0, 8191)));
        send_sample(v, 10'd1023);
    endtask

    initial
    begin
        err_count = 0;
        burst_left = 0;
        gap_max = 0;
        stall_mode = 0;
        stall_run = 0;
        held_count = 0;
        peak_logit = 0;
        logit_sum = 0;
        eps_q16 = '0;
        build_exp_tables();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();                 // smoothing from reset: one-hot
        drain();
        set_smoothing(16'hFFFF);
        gap_max = 6;
        stall_mode = 1;
        test_directed();
        drain();
        set_smoothing(16'h8000);
        test_random_samples(250);
        drain();
        set_smoothing(16'h0000);
        stall_mode = 2;
        test_random_samples(250);
        drain();
        set_smoothing(16'($urandom));
        gap_max = 0;
        stall_mode = 0;
        test_random_samples(250);
        drain();
        set_smoothing(16'($urandom));
        gap_max = 3;
        stall_mode = 1;
        test_store_overflow();
        drain();

        if (err_count == 0)
            $display("softmax_cross_entropy_smoothed_core_test passed");
        else
            $display("softmax_cross_entropy_smoothed_core_test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #10000000;
        $display("softmax_cross_entropy_smoothed_core_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sce_pkg.sv
rtl/sce_front.sv
rtl/sce_queue.sv
rtl/sce_back.sv
rtl/softmax_cross_entropy_smoothed_core.sv
bench/softmax_cross_entropy_smoothed_core_test.sv
